### rtl/sha_pkg.sv
// Package with SHA-256 constants, types and round functions.
package sha_pkg;

   localparam int unsigned BlockBytes = 64;
   localparam int unsigned LengthOffset = 56;
   localparam logic [7:0] PadByte = 8'h80;

   typedef logic [255:0] chain_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       write_byte;
      logic [7:0] wdata;
      logic       count_byte;
      logic       start_block;
      logic       do_round;
      logic       finish_block;
      logic       restart;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic       block_full;
      logic [5:0] fill;
      logic [5:0] round;
      logic [63:0] bit_len;
   } dp_status_type;

   function automatic logic [31:0] round_const(input logic [5:0] i);
      logic [31:0] k [64];
      k = '{
         32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
         32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
         32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
         32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
         32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
         32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
         32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
         32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
         32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
         32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
         32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};
      return k[i];
   endfunction

   localparam chain_type InitVector = {
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

   function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned r);
      return (x >> r) | (x << (32 - r));
   endfunction

endpackage

### rtl/sha_stream_if.sv
// Valid/ready stream interfaces for request and response channels.
interface sha_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       byte_present;
   logic       end_of_message;
   modport source (output valid, data_byte, byte_present, end_of_message, input ready);
   modport sink (input valid, data_byte, byte_present, end_of_message, output ready);
endinterface

interface sha_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic [2:0]  word_index;
   logic        last_word;
   modport source (output valid, digest_word, word_index, last_word, input ready);
   modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

### rtl/sha_datapath.sv
// Datapath: byte packing into the message schedule, round logic and chaining words.
module sha_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  sha_pkg::dp_cmd_type    cmd,
   output sha_pkg::dp_status_type status,
   output sha_pkg::chain_type     chain
);

   logic [5:0]  fill_ff, fill_in;
   logic        full_ff, full_in;
   logic [63:0] len_ff, len_in;
   logic [5:0]  round_ff, round_in;
   logic [31:0] w_ff [16];
   logic [31:0] v_ff [8];
   sha_pkg::chain_type chain_ff, chain_in;
   logic [31:0] wi, s0, s1, ch, mj, t1, t2, e0, e1, w15, w2;

   // Schedule word and round function for the current round.
   always_comb begin
      w15 = w_ff[4'(round_ff + 6'd1)];
      w2  = w_ff[4'(round_ff + 6'd14)];
      s0  = sha_pkg::rotr(w15, 7) ^ sha_pkg::rotr(w15, 18) ^ (w15 >> 3);
      s1  = sha_pkg::rotr(w2, 17) ^ sha_pkg::rotr(w2, 19) ^ (w2 >> 10);
      if (round_ff < 6'd16) begin
         wi = w_ff[round_ff[3:0]];
      end else begin
         wi = w_ff[round_ff[3:0]] + s0 + w_ff[4'(round_ff + 6'd9)] + s1;
      end
      e1 = sha_pkg::rotr(v_ff[4], 6) ^ sha_pkg::rotr(v_ff[4], 11) ^ sha_pkg::rotr(v_ff[4], 25);
      ch = (v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]);
      t1 = v_ff[7] + e1 + ch + sha_pkg::round_const(round_ff) + wi;
      e0 = sha_pkg::rotr(v_ff[0], 2) ^ sha_pkg::rotr(v_ff[0], 13) ^ sha_pkg::rotr(v_ff[0], 22);
      mj = (v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]);
      t2 = e0 + mj;
   end

   // Control counters and chaining words.
   always_comb begin
      fill_in  = fill_ff;
      full_in  = full_ff;
      len_in   = len_ff;
      round_in = round_ff;
      chain_in = chain_ff;
      if (cmd.count_byte) len_in = len_ff + 64'd1;
      if (cmd.write_byte) begin
         fill_in = fill_ff + 6'd1;
         full_in = (fill_ff == 6'd63);
      end
      if (cmd.start_block) begin
         round_in = '0;
         full_in  = 1'b0;
      end
      if (cmd.do_round) round_in = round_ff + 6'd1;
      if (cmd.finish_block) begin
         for (int k = 0; k < 8; k++) begin
            chain_in[255-32*k -: 32] = chain_ff[255-32*k -: 32] + v_ff[k];
         end
      end
      if (cmd.restart) begin
         chain_in = sha_pkg::InitVector;
         len_in   = '0;
         fill_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff  <= '0;
         full_ff  <= 1'b0;
         len_ff   <= '0;
         round_ff <= '0;
         chain_ff <= sha_pkg::InitVector;
      end else begin
         fill_ff  <= fill_in;
         full_ff  <= full_in;
         len_ff   <= len_in;
         round_ff <= round_in;
         chain_ff <= chain_in;
      end
   end

   // Schedule and working registers: bytes are packed straight into the schedule words,
   // the first byte of a word highest; at block start the working words are loaded,
   // then one round runs per cycle.
   always_ff @(posedge clock) begin
      if (cmd.start_block) begin
         for (int k = 0; k < 8; k++) v_ff[k] <= chain_ff[255-32*k -: 32];
      end else if (cmd.do_round) begin
         w_ff[round_ff[3:0]] <= wi;
         v_ff[7] <= v_ff[6];
         v_ff[6] <= v_ff[5];
         v_ff[5] <= v_ff[4];
         v_ff[4] <= v_ff[3] + t1;
         v_ff[3] <= v_ff[2];
         v_ff[2] <= v_ff[1];
         v_ff[1] <= v_ff[0];
         v_ff[0] <= t1 + t2;
      end else if (cmd.write_byte) begin
         w_ff[fill_ff[5:2]][{~fill_ff[1:0], 3'b000} +: 8] <= cmd.wdata;
      end
   end

   assign status.block_full = full_ff;
   assign status.fill       = fill_ff;
   assign status.round      = round_ff;
   assign status.bit_len    = {len_ff[60:0], 3'b000};
   assign chain = chain_ff;

endmodule

### rtl/sha_controller.sv
// Controller: accepts bytes, sequences padding, compression and digest output.
module sha_controller (
   input  logic                   clock,
   input  logic                   reset,
   sha_req_if.sink                req,
   sha_rsp_if.source              rsp,
   input  sha_pkg::dp_status_type status,
   input  sha_pkg::chain_type     chain,
   output sha_pkg::dp_cmd_type    cmd
);

   typedef enum logic [2:0] {
      S_IDLE, S_LOAD, S_ROUND, S_ADD, S_PAD, S_OUT
   } state_type;

   state_type   state_ff, state_in;
   logic        fin_ff, fin_in;
   logic        pad_ff, pad_in;
   logic        len_blk_ff, len_blk_in;
   logic [63:0] bits_ff, bits_in;
   logic [2:0]  idx_ff, idx_in;
   logic        take;

   assign req.ready = (state_ff == S_IDLE);
   assign take = req.valid && req.ready;

   // Next-state and command logic.
   always_comb begin
      state_in   = state_ff;
      fin_in     = fin_ff;
      pad_in     = pad_ff;
      len_blk_in = len_blk_ff;
      bits_in    = bits_ff;
      idx_in     = idx_ff;
      cmd        = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (take) begin
               cmd.write_byte = req.byte_present;
               cmd.wdata      = req.data_byte;
               cmd.count_byte = req.byte_present;
               if (req.end_of_message) begin
                  fin_in   = 1'b1;
                  pad_in   = 1'b1;
                  state_in = S_PAD;
               end else if (req.byte_present && status.fill == 6'd63) begin
                  state_in = S_LOAD;
               end
            end
         end
         S_PAD: begin
            if (status.block_full) begin
               state_in = S_LOAD;
            end else begin
               cmd.write_byte = 1'b1;
               if (pad_ff) begin
                  // The length fits in this block only if the pad byte lands before it.
                  cmd.wdata  = sha_pkg::PadByte;
                  bits_in    = status.bit_len;
                  pad_in     = 1'b0;
                  len_blk_in = (status.fill < 6'(sha_pkg::LengthOffset));
               end else if (len_blk_ff && status.fill >= 6'(sha_pkg::LengthOffset)) begin
                  cmd.wdata = bits_ff[63:56];
                  bits_in   = {bits_ff[55:0], 8'h00};
               end else begin
                  cmd.wdata = 8'h00;
               end
               if (status.fill == 6'd63) state_in = S_LOAD;
            end
         end
         S_LOAD: begin
            cmd.start_block = 1'b1;
            state_in = S_ROUND;
         end
         S_ROUND: begin
            cmd.do_round = 1'b1;
            if (status.round == 6'd63) state_in = S_ADD;
         end
         S_ADD: begin
            cmd.finish_block = 1'b1;
            if (!fin_ff) state_in = S_IDLE;
            else if (pad_ff || !len_blk_ff) begin
               state_in   = S_PAD;
               len_blk_in = 1'b1;
            end else begin
               state_in = S_OUT;
               idx_in   = '0;
            end
         end
         S_OUT: begin
            if (rsp.ready) begin
               idx_in = idx_ff + 3'd1;
               if (idx_ff == 3'd7) begin
                  cmd.restart = 1'b1;
                  fin_in      = 1'b0;
                  len_blk_in  = 1'b0;
                  state_in    = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         fin_ff     <= 1'b0;
         pad_ff     <= 1'b0;
         len_blk_ff <= 1'b0;
         bits_ff    <= '0;
         idx_ff     <= '0;
      end else begin
         state_ff   <= state_in;
         fin_ff     <= fin_in;
         pad_ff     <= pad_in;
         len_blk_ff <= len_blk_in;
         bits_ff    <= bits_in;
         idx_ff     <= idx_in;
      end
   end

   assign rsp.valid       = (state_ff == S_OUT);
   assign rsp.digest_word = chain[255 - 32*idx_ff -: 32];
   assign rsp.word_index  = idx_ff;
   assign rsp.last_word   = (idx_ff == 3'd7);

`ifndef SYNTHESIS
   a_no_req_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !req.ready) else $error("ready while busy");
   a_last: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.ready && rsp.last_word) |=> (state_ff == S_IDLE))
      else $error("no return to idle after last word");
   a_round_run: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LOAD) |=> (state_ff == S_ROUND && status.round == 6'd0))
      else $error("round counter not cleared");
`endif

endmodule

### rtl/sha256_message_digest_unit.sv
// Top level of the SHA-256 message digest unit.
//  channel | dir | fields
//  req     | in  | data_byte[7:0], byte_present, end_of_message
//  rsp     | out | digest_word[31:0], word_index[2:0], last_word
// A byte transfer is taken while the unit is idle; the 64th byte of a block then
// runs the one-round-per-cycle compression loop before the next byte is accepted.
// A closing transfer pads the message, compresses one or two blocks,
// then presents eight words, each held until rsp.ready.
// Synchronous active-high reset restores the initial vector.
module sha256_message_digest_unit (
   input logic       clock,
   input logic       reset,
   sha_req_if.sink   req,
   sha_rsp_if.source rsp
);

   sha_pkg::dp_cmd_type    cmd;
   sha_pkg::dp_status_type status;
   sha_pkg::chain_type     chain;

   sha_controller u_ctrl (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .status(status), .chain(chain), .cmd(cmd));

   sha_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .status(status), .chain(chain));

endmodule
